/* hw/rtl/atilt_pkg.sv */
package atilt_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_LEN          = 24;
   localparam int ROOT_STEPS        = 32;
   localparam int MAG_STEPS         = 16;
   localparam int ANGLE_LIMIT       = 23040;

   typedef struct packed {
      logic [30:0]        xx;
      logic [30:0]        yy;
      logic [30:0]        zz;
      logic signed [16:0] num_r;
      logic signed [16:0] num_p;
   } square_type;

   typedef struct packed {
      logic [34:0]        rem_r;
      logic [34:0]        rem_p;
      logic [31:0]        q_r;
      logic [31:0]        q_p;
      logic [31:0]        d_r;
      logic [31:0]        d_p;
      logic [18:0]        rem_m;
      logic [15:0]        q_m;
      logic [31:0]        d_m;
      logic signed [16:0] num_r;
      logic signed [16:0] num_p;
   } root_type;

   typedef struct packed {
      logic signed [35:0] xr;
      logic signed [35:0] yr;
      logic signed [24:0] ar;
      logic signed [35:0] xp;
      logic signed [35:0] yp;
      logic signed [24:0] ap;
      logic               zero_r;
      logic               zero_p;
      logic signed [16:0] num_r;
      logic signed [16:0] num_p;
      logic [15:0]        mag;
   } angle_type;

   function automatic logic [21:0] atan_lut(input int unsigned idx);
      logic [21:0] t;
      case (idx)
         0:  t = 22'd2949120;
         1:  t = 22'd1740967;
         2:  t = 22'd919879;
         3:  t = 22'd466945;
         4:  t = 22'd234379;
         5:  t = 22'd117304;
         6:  t = 22'd58666;
         7:  t = 22'd29335;
         8:  t = 22'd14668;
         9:  t = 22'd7334;
         10: t = 22'd3667;
         11: t = 22'd1833;
         12: t = 22'd917;
         13: t = 22'd458;
         14: t = 22'd229;
         15: t = 22'd115;
         16: t = 22'd57;
         17: t = 22'd29;
         18: t = 22'd14;
         19: t = 22'd7;
         20: t = 22'd4;
         21: t = 22'd2;
         22: t = 22'd1;
         default: t = 22'd0;
      endcase
      return t;
   endfunction

endpackage

/* hw/rtl/accel_tilt_angle.sv */
// Channel   Direction  Ports                                   Word
// req       in         req_valid req_ready req_accel_x/y/z      one sample
// rsp       out        rsp_valid rsp_ready rsp_roll_angle       one result
//                      rsp_pitch_angle rsp_total_magnitude
//
// The pipeline registers are squares, sums, 32 root steps, one
// CORDIC stage per step, and the output register.
// One sample enters per cycle while req_ready is high; the pipeline takes a word each cycle unless rsp stalls.
// Every stage holds its own valid bit and advances when the next one is free,
// so a stalled rsp fills bubbles before req_ready drops.
// Synchronous reset clears valid bits only.
module accel_tilt_angle #(
   parameter int CORDIC_STAGES = atilt_pkg::CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [15:0] rsp_pitch_angle,
   output logic [15:0]        rsp_total_magnitude
);
   import atilt_pkg::*;

   logic      rt_v   [ROOT_STEPS+1];
   logic      rt_r   [ROOT_STEPS+1];
   root_type  rt_d   [ROOT_STEPS+1];
   logic      co_v   [CORDIC_STAGES+1];
   logic      co_r   [CORDIC_STAGES+1];
   angle_type co_d   [CORDIC_STAGES+1];

   logic               out_v_ff;
   logic signed [15:0] roll_ff, roll_in, pitch_ff, pitch_in;
   logic [15:0]        mag_ff;
   logic signed [25:0] sum_r, sum_p;
   logic signed [17:0] sh_r, sh_p;

   atilt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_x      (req_accel_x),
      .in_y      (req_accel_y),
      .in_z      (req_accel_z),
      .out_valid (rt_v[0]),
      .out_ready (rt_r[0]),
      .out_data  (rt_d[0])
   );

   for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
      atilt_root_step #(.STEP(i)) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (rt_v[i]),
         .in_ready  (rt_r[i]),
         .in_data   (rt_d[i]),
         .out_valid (rt_v[i+1]),
         .out_ready (rt_r[i+1]),
         .out_data  (rt_d[i+1])
      );
   end

   assign co_v[0]        = rt_v[ROOT_STEPS];
   assign rt_r[ROOT_STEPS] = co_r[0];

   always_comb begin
      co_d[0]        = '0;
      co_d[0].xr     = $signed({4'b0000, rt_d[ROOT_STEPS].q_r});
      co_d[0].yr     = 36'(rt_d[ROOT_STEPS].num_r) <<< 16;
      co_d[0].xp     = $signed({4'b0000, rt_d[ROOT_STEPS].q_p});
      co_d[0].yp     = 36'(rt_d[ROOT_STEPS].num_p) <<< 16;
      co_d[0].zero_r = (rt_d[ROOT_STEPS].q_r == '0);
      co_d[0].zero_p = (rt_d[ROOT_STEPS].q_p == '0);
      co_d[0].num_r  = rt_d[ROOT_STEPS].num_r;
      co_d[0].num_p  = rt_d[ROOT_STEPS].num_p;
      co_d[0].mag    = rt_d[ROOT_STEPS].q_m;
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      atilt_cordic_step #(.STEP(i)) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (co_v[i]),
         .in_ready  (co_r[i]),
         .in_data   (co_d[i]),
         .out_valid (co_v[i+1]),
         .out_ready (co_r[i+1]),
         .out_data  (co_d[i+1])
      );
   end

   assign co_r[CORDIC_STAGES] = !out_v_ff || rsp_ready;

   always_comb begin
      sum_r = 26'(co_d[CORDIC_STAGES].ar) + 26'sd128;
      sum_p = 26'(co_d[CORDIC_STAGES].ap) + 26'sd128;
      sh_r  = 18'(sum_r >>> 8);
      sh_p  = 18'(sum_p >>> 8);
      if (sh_r > 18'(ANGLE_LIMIT)) roll_in = 16'(ANGLE_LIMIT);
      else if (sh_r < -18'(ANGLE_LIMIT)) roll_in = -16'(ANGLE_LIMIT);
      else roll_in = 16'(sh_r);
      if (sh_p > 18'(ANGLE_LIMIT)) pitch_in = 16'(ANGLE_LIMIT);
      else if (sh_p < -18'(ANGLE_LIMIT)) pitch_in = -16'(ANGLE_LIMIT);
      else pitch_in = 16'(sh_p);
      if (co_d[CORDIC_STAGES].zero_r) begin
         if (co_d[CORDIC_STAGES].num_r == '0) roll_in = '0;
         else if (co_d[CORDIC_STAGES].num_r[16]) roll_in = -16'(ANGLE_LIMIT);
         else roll_in = 16'(ANGLE_LIMIT);
      end
      if (co_d[CORDIC_STAGES].zero_p) begin
         if (co_d[CORDIC_STAGES].num_p == '0) pitch_in = '0;
         else if (co_d[CORDIC_STAGES].num_p[16]) pitch_in = -16'(ANGLE_LIMIT);
         else pitch_in = 16'(ANGLE_LIMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (co_r[CORDIC_STAGES]) begin
         out_v_ff <= co_v[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (co_r[CORDIC_STAGES] && co_v[CORDIC_STAGES]) begin
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
         mag_ff   <= co_d[CORDIC_STAGES].mag;
      end
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_roll_angle      = roll_ff;
   assign rsp_pitch_angle     = pitch_ff;
   assign rsp_total_magnitude = mag_ff;

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_angle <= 16'sd23040) && (rsp_roll_angle >= -16'sd23040))
      else $error("roll angle out of range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 16'sd23040) && (rsp_pitch_angle >= -16'sd23040))
      else $error("pitch angle out of range");

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_total_magnitude <= 16'd56755)
      else $error("magnitude out of range");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output register");

endmodule

/* hw/rtl/atilt_front.sv */
module atilt_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [15:0]       in_x,
   input  logic signed [15:0]       in_y,
   input  logic signed [15:0]       in_z,
   output logic                     out_valid,
   input  logic                     out_ready,
   output atilt_pkg::root_type      out_data
);
   import atilt_pkg::*;

   logic       sq_v_ff;
   square_type sq_ff, sq_in;
   logic       sq_ready;
   logic       rt_v_ff;
   root_type   rt_ff, rt_in;
   logic [31:0] x2, y2, z2;

   assign x2 = $unsigned(32'(in_x) * 32'(in_x));
   assign y2 = $unsigned(32'(in_y) * 32'(in_y));
   assign z2 = $unsigned(32'(in_z) * 32'(in_z));

   always_comb begin
      sq_in.xx    = x2[30:0];
      sq_in.yy    = y2[30:0];
      sq_in.zz    = z2[30:0];
      sq_in.num_r = 17'(in_y);
      sq_in.num_p = -17'(in_x);
   end

   always_comb begin
      rt_in       = '0;
      rt_in.d_r   = {1'b0, sq_ff.xx} + {1'b0, sq_ff.zz};
      rt_in.d_p   = {1'b0, sq_ff.yy} + {1'b0, sq_ff.zz};
      rt_in.d_m   = {1'b0, sq_ff.xx} + {1'b0, sq_ff.yy} + {1'b0, sq_ff.zz};
      rt_in.num_r = sq_ff.num_r;
      rt_in.num_p = sq_ff.num_p;
   end

   assign sq_ready  = !rt_v_ff || out_ready;
   assign in_ready  = !sq_v_ff || sq_ready;
   assign out_valid = rt_v_ff;
   assign out_data  = rt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= 1'b0;
         rt_v_ff <= 1'b0;
      end else begin
         if (in_ready) sq_v_ff <= in_valid;
         if (sq_ready) rt_v_ff <= sq_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) sq_ff <= sq_in;
      if (sq_ready && sq_v_ff) rt_ff <= rt_in;
   end

endmodule

/* hw/rtl/atilt_root_step.sv */
module atilt_root_step #(
   parameter int STEP = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  atilt_pkg::root_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output atilt_pkg::root_type out_data
);
   import atilt_pkg::*;

   logic     v_ff;
   root_type p_ff, p_in;
   logic [34:0] rr, tr, rp, tp;
   logic [18:0] rm, tm;

   always_comb begin
      p_in = in_data;
      rr = {in_data.rem_r[32:0], in_data.d_r[31:30]};
      tr = {1'b0, in_data.q_r, 2'b01};
      rp = {in_data.rem_p[32:0], in_data.d_p[31:30]};
      tp = {1'b0, in_data.q_p, 2'b01};
      rm = {in_data.rem_m[16:0], in_data.d_m[31:30]};
      tm = {1'b0, in_data.q_m, 2'b01};
      p_in.d_r = {in_data.d_r[29:0], 2'b00};
      p_in.d_p = {in_data.d_p[29:0], 2'b00};
      if (rr >= tr) begin
         p_in.rem_r = rr - tr;
         p_in.q_r   = {in_data.q_r[30:0], 1'b1};
      end else begin
         p_in.rem_r = rr;
         p_in.q_r   = {in_data.q_r[30:0], 1'b0};
      end
      if (rp >= tp) begin
         p_in.rem_p = rp - tp;
         p_in.q_p   = {in_data.q_p[30:0], 1'b1};
      end else begin
         p_in.rem_p = rp;
         p_in.q_p   = {in_data.q_p[30:0], 1'b0};
      end
      if (STEP < MAG_STEPS) begin
         p_in.d_m = {in_data.d_m[29:0], 2'b00};
         if (rm >= tm) begin
            p_in.rem_m = rm - tm;
            p_in.q_m   = {in_data.q_m[14:0], 1'b1};
         end else begin
            p_in.rem_m = rm;
            p_in.q_m   = {in_data.q_m[14:0], 1'b0};
         end
      end
   end

   assign in_ready  = !v_ff || out_ready;
   assign out_valid = v_ff;
   assign out_data  = p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) p_ff <= p_in;
   end

endmodule

/* hw/rtl/atilt_cordic_step.sv */
module atilt_cordic_step #(
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  atilt_pkg::angle_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output atilt_pkg::angle_type out_data
);
   import atilt_pkg::*;

   localparam logic signed [24:0] T = $signed({3'b000, atan_lut(STEP)});

   logic      v_ff;
   angle_type p_ff, p_in;

   always_comb begin
      p_in = in_data;
      if (!in_data.yr[35]) begin
         p_in.xr = in_data.xr + (in_data.yr >>> STEP);
         p_in.yr = in_data.yr - (in_data.xr >>> STEP);
         p_in.ar = in_data.ar + T;
      end else begin
         p_in.xr = in_data.xr - (in_data.yr >>> STEP);
         p_in.yr = in_data.yr + (in_data.xr >>> STEP);
         p_in.ar = in_data.ar - T;
      end
      if (!in_data.yp[35]) begin
         p_in.xp = in_data.xp + (in_data.yp >>> STEP);
         p_in.yp = in_data.yp - (in_data.xp >>> STEP);
         p_in.ap = in_data.ap + T;
      end else begin
         p_in.xp = in_data.xp - (in_data.yp >>> STEP);
         p_in.yp = in_data.yp + (in_data.xp >>> STEP);
         p_in.ap = in_data.ap - T;
      end
   end

   assign in_ready  = !v_ff || out_ready;
   assign out_valid = v_ff;
   assign out_data  = p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) p_ff <= p_in;
   end

endmodule

/* dv/tb_top.sv */
module tb_top;
   import atilt_pkg::*;

   localparam int STAGES  = CORDIC_STAGES_DEF;
   localparam int LATENCY = 35 + STAGES;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic [15:0]        mag;
   } tilt_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_accel_x = '0;
   logic signed [15:0] req_accel_y = '0;
   logic signed [15:0] req_accel_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_roll_angle;
   logic signed [15:0] rsp_pitch_angle;
   logic [15:0]        rsp_total_magnitude;

   tilt_word_type expected_tilts[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   accel_tilt_angle uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_accel_x(req_accel_x), .req_accel_y(req_accel_y), .req_accel_z(req_accel_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_roll_angle(rsp_roll_angle), .rsp_pitch_angle(rsp_pitch_angle),
      .rsp_total_magnitude(rsp_total_magnitude)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [15:0] tilt_degrees(longint num, longint unsigned sumsq);
      longint unsigned root;
      longint xv, yv, acc, dx, dy, res;
      root = int_sqrt(sumsq << 32);
      if (root == 0) begin
         if (num == 0) return 16'sd0;
         return num > 0 ? 16'(ANGLE_LIMIT) : 16'(-ANGLE_LIMIT);
      end
      xv = longint'(root);
      yv = num * 65536;
      acc = 0;
      for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
         dx = yv >>> i;
         dy = xv >>> i;
         if (yv >= 0) begin
            xv += dx;
            yv -= dy;
            acc += longint'(atan_lut(i));
         end else begin
            xv -= dx;
            yv += dy;
            acc -= longint'(atan_lut(i));
         end
      end
      res = (acc + 128) >>> 8;
      if (res > ANGLE_LIMIT) res = ANGLE_LIMIT;
      if (res < -ANGLE_LIMIT) res = -ANGLE_LIMIT;
      return 16'(res);
   endfunction

   function automatic tilt_word_type predict_tilt(logic signed [15:0] ax,
                                                  logic signed [15:0] ay,
                                                  logic signed [15:0] az);
      longint x, y, z;
      longint unsigned xx, yy, zz;
      tilt_word_type w;
      x = ax;
      y = ay;
      z = az;
      xx = x * x;
      yy = y * y;
      zz = z * z;
      w.roll = tilt_degrees(y, xx + zz);
      w.pitch = tilt_degrees(-x, yy + zz);
      w.mag = 16'(int_sqrt(xx + yy + zz));
      return w;
   endfunction

   task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_tilts.push_back(predict_tilt(ax, ay, az));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tilts.size() == 0) begin
               $error("unexpected result word");
               errors++;
            end else begin
               tilt_word_type e;
               e = expected_tilts.pop_front();
               if (rsp_roll_angle !== e.roll) begin
                  $error("roll_angle exp %0d got %0d", e.roll, rsp_roll_angle);
                  errors++;
               end
               if (rsp_pitch_angle !== e.pitch) begin
                  $error("pitch_angle exp %0d got %0d", e.pitch, rsp_pitch_angle);
                  errors++;
               end
               if (rsp_total_magnitude !== e.mag) begin
                  $error("total_magnitude exp %0d got %0d", e.mag, rsp_total_magnitude);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic signed [15:0] rand_axis();
      case ($urandom_range(5))
         0: return 16'($urandom_range(65535));
         1: return 16'($signed($urandom_range(16)) - 8);
         2: return $urandom_range(1) ? 16'sh7fff - 16'($urandom_range(4))
                                     : 16'sh8000 + 16'($urandom_range(4));
         3: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
         4: return 16'sd0;
         default: return 16'($signed($urandom_range(4095)) - 2048);
      endcase
   endfunction

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_tilts.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic signed [15:0] ext[6] = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd16384};
      send_sample(16'sd0, 16'sd0, 16'sd0);
      send_sample(16'sd0, 16'sd0, 16'sd16384);
      send_sample(16'sd0, 16'sd5, 16'sd0);
      send_sample(16'sd0, -16'sd5, 16'sd0);
      send_sample(16'sd7, 16'sd0, 16'sd0);
      send_sample(-16'sd7, 16'sd0, 16'sd0);
      send_sample(16'sh8000, 16'sh8000, 16'sh8000);
      send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
      send_sample(16'sh5555, 16'shaaaa, 16'sh1234);
      send_sample(16'shaaaa, 16'sh5555, 16'shedcb);
      for (int i = 0; i < 6; i++) send_sample(ext[i], ext[(i + 1) % 6], ext[(i + 3) % 6]);
   endtask

   task automatic test_random(int n, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < n; i++) send_sample(rand_axis(), rand_axis(), rand_axis());
   endtask

   task automatic test_pause_drain();
      test_random(20, 0, 30);
      wait_drain();
      test_random(20, 0, 0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(400, 0, 0);
      test_random(350, 61, 0);
      test_random(350, 0, 61);
      test_random(350, 27, 27);
      test_pause_drain();
      recv_stall_pct = 0;
      wait_drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && expected_tilts.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
